// ===== hw/rtl/mbsp_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI byte stream parser package
// Types, constants and status decode tables shared by the parser files.
// ----------------------------------------------------------------------------
`default_nettype none

package mbsp_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned KIND_W  = 5;
	localparam int unsigned CHAN_W  = 5;
	localparam int unsigned DATA_W  = 7;
	localparam int unsigned COUNT_W = 2;
	localparam int unsigned TDATA_W = 24;

	typedef logic [KIND_W-1:0]  kind_t;
	typedef logic [CHAN_W-1:0]  chan_t;
	typedef logic [DATA_W-1:0]  data_t;
	typedef logic [COUNT_W-1:0] count_t;

	localparam logic [BYTE_W-1:0] STATUS_MASK = 8'h80;
	localparam logic [3:0]        SYS_NIBBLE  = 4'hF;

	localparam kind_t KIND_START         = 5'd0;
	localparam kind_t KIND_CONTINUE      = 5'd1;
	localparam kind_t KIND_STOP          = 5'd2;
	localparam kind_t KIND_CLOCK         = 5'd3;
	localparam kind_t KIND_TICK          = 5'd4;
	localparam kind_t KIND_ACT_SENSE     = 5'd5;
	localparam kind_t KIND_RESET         = 5'd6;
	localparam kind_t KIND_TUNE_REQ      = 5'd7;
	localparam kind_t KIND_PROG_CHANGE   = 5'd8;
	localparam kind_t KIND_CHAN_PRESSURE = 5'd9;
	localparam kind_t KIND_QUARTER_FRAME = 5'd10;
	localparam kind_t KIND_SONG_SELECT   = 5'd11;
	localparam kind_t KIND_NOTE_ON       = 5'd12;
	localparam kind_t KIND_NOTE_OFF      = 5'd13;
	localparam kind_t KIND_CTRL_CHANGE   = 5'd14;
	localparam kind_t KIND_PITCH_BEND    = 5'd15;
	localparam kind_t KIND_POLY_PRESSURE = 5'd16;
	localparam kind_t KIND_SONG_POS      = 5'd17;
	localparam kind_t KIND_NONE          = 5'd31;

	localparam chan_t CHAN_BROADCAST = 5'd16;

	// decode of system status low nibble (0xF0..0xFF)
	function automatic kind_t sys_kind(input logic [3:0] nib);
		kind_t k;
		case (nib)
			4'h1:    k = KIND_QUARTER_FRAME;
			4'h2:    k = KIND_SONG_POS;
			4'h3:    k = KIND_SONG_SELECT;
			4'h6:    k = KIND_TUNE_REQ;
			4'h8:    k = KIND_CLOCK;
			4'h9:    k = KIND_TICK;
			4'hA:    k = KIND_START;
			4'hB:    k = KIND_CONTINUE;
			4'hC:    k = KIND_STOP;
			4'hE:    k = KIND_ACT_SENSE;
			4'hF:    k = KIND_RESET;
			default: k = KIND_NONE;
		endcase
		return k;
	endfunction

	// decode of channel status high nibble (0x8..0xE)
	function automatic kind_t chan_kind(input logic [3:0] nib);
		kind_t k;
		case (nib)
			4'h8:    k = KIND_NOTE_OFF;
			4'h9:    k = KIND_NOTE_ON;
			4'hA:    k = KIND_POLY_PRESSURE;
			4'hB:    k = KIND_CTRL_CHANGE;
			4'hC:    k = KIND_PROG_CHANGE;
			4'hD:    k = KIND_CHAN_PRESSURE;
			default: k = KIND_PITCH_BEND;
		endcase
		return k;
	endfunction

	function automatic count_t data_len(input kind_t kind);
		count_t n;
		case (kind)
			KIND_PROG_CHANGE, KIND_CHAN_PRESSURE,
			KIND_QUARTER_FRAME, KIND_SONG_SELECT:       n = 2'd1;
			KIND_NOTE_ON, KIND_NOTE_OFF, KIND_CTRL_CHANGE,
			KIND_PITCH_BEND, KIND_POLY_PRESSURE,
			KIND_SONG_POS:                              n = 2'd2;
			default:                                    n = 2'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/midi_byte_stream_parser_unit.sv =====
// ----------------------------------------------------------------------------
// MIDI byte stream parser unit
// Decodes a MIDI 1.0 byte stream into events without running status.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                    | tuser
//  s_      | in  | midi_byte                | -
//  m_      | out | channel, first, second   | event_kind
//
// One byte per cycle while no stall on m_tready holds the event; an input transfer
// reaches m_tvalid through the input register and then the event register.
// Held message state updates as a byte leaves the input register.
// arst_n clears valid flags and held state (channel to all channels).
// A stall on m_tready holds the event and, once the input register is full,
// holds s_tready low.
`default_nettype none

module midi_byte_stream_parser_unit (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	input  wire  [mbsp_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] midi_byte
	output logic                           m_tvalid,
	input  wire                            m_tready,
	output logic [mbsp_pkg::TDATA_W-1:0]   m_tdata,   // [4:0] channel, [11:5] first_data,
	                                                  // [18:12] second_data, [23:19] zero
	output logic [mbsp_pkg::KIND_W-1:0]    m_tuser    // [4:0] event_kind
);
	import mbsp_pkg::*;

	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                advance;

	kind_t  held_kind_q,   held_kind_d;
	chan_t  held_chan_q,   held_chan_d;
	data_t  held_first_q,  held_first_d;
	data_t  held_second_q, held_second_d;
	count_t expect_q,      expect_d;
	logic   emit;

	logic   out_valid_q;
	kind_t  out_kind_q;
	chan_t  out_chan_q;
	data_t  out_first_q;
	data_t  out_second_q;

	kind_t  st_kind;
	chan_t  st_chan;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	always_comb begin
		if (byte_s1[7:4] == SYS_NIBBLE) begin
			st_kind = sys_kind(byte_s1[3:0]);
			st_chan = CHAN_BROADCAST;
		end else begin
			st_kind = chan_kind(byte_s1[7:4]);
			st_chan = {1'b0, byte_s1[3:0]};
		end
	end

	always_comb begin
		held_kind_d   = held_kind_q;
		held_chan_d   = held_chan_q;
		held_first_d  = held_first_q;
		held_second_d = held_second_q;
		expect_d      = expect_q;
		emit          = 1'b0;
		if ((byte_s1 & STATUS_MASK) != '0) begin
			expect_d = '0;
			if (st_kind != KIND_NONE) begin
				held_kind_d   = st_kind;
				held_chan_d   = st_chan;
				held_first_d  = '0;
				held_second_d = '0;
				expect_d      = data_len(st_kind);
				emit          = (data_len(st_kind) == '0);
			end
		end else if (expect_q != '0) begin
			if (data_len(held_kind_q) == 2'd2 && expect_q == 2'd2) begin
				held_first_d = byte_s1[DATA_W-1:0];
			end else if (data_len(held_kind_q) == 2'd2) begin
				held_second_d = byte_s1[DATA_W-1:0];
			end else begin
				held_first_d = byte_s1[DATA_W-1:0];
			end
			expect_d = expect_q - 2'd1;
			emit     = (expect_q == 2'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_kind_q   <= '0;
			held_chan_q   <= CHAN_BROADCAST;
			held_first_q  <= '0;
			held_second_q <= '0;
			expect_q      <= '0;
			out_valid_q   <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
			if (valid_s1) begin
				held_kind_q   <= held_kind_d;
				held_chan_q   <= held_chan_d;
				held_first_q  <= held_first_d;
				held_second_q <= held_second_d;
				expect_q      <= expect_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			out_kind_q   <= held_kind_d;
			out_chan_q   <= held_chan_d;
			out_first_q  <= held_first_d;
			out_second_q <= held_second_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {5'd0, out_second_q, out_first_q, out_chan_q};

endmodule

`default_nettype wire

// ===== hw/rtl/mbsp_checker.sv =====
// ----------------------------------------------------------------------------
// MIDI byte stream parser checker
// Port-level checks on the event stream of the parser unit.
// ----------------------------------------------------------------------------
`default_nettype none

module mbsp_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            s_tvalid,
	input wire                            s_tready,
	input wire [mbsp_pkg::BYTE_W-1:0]     s_tdata,
	input wire                            m_tvalid,
	input wire                            m_tready,
	input wire [mbsp_pkg::TDATA_W-1:0]    m_tdata,
	input wire [mbsp_pkg::KIND_W-1:0]     m_tuser
);
	import mbsp_pkg::*;

	logic unused_in;
	assign unused_in = s_tvalid ^ s_tready ^ (^s_tdata);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("event changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= KIND_SONG_POS && m_tdata[23:19] == '0)
		else $error("event kind out of range");

	a_one_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser <= KIND_TUNE_REQ |->
			m_tdata[4:0] == CHAN_BROADCAST && m_tdata[18:5] == '0)
		else $error("one-byte message carries data or channel");

	a_two_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser >= KIND_PROG_CHANGE && m_tuser <= KIND_SONG_SELECT |->
			m_tdata[18:12] == '0)
		else $error("two-byte message carries second data");

	a_chan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_PROG_CHANGE || m_tuser == KIND_CHAN_PRESSURE ||
			(m_tuser >= KIND_NOTE_ON && m_tuser <= KIND_POLY_PRESSURE)) |->
			m_tdata[4] == 1'b0)
		else $error("channel message without a channel");

endmodule

bind midi_byte_stream_parser_unit mbsp_checker u_mbsp_checker (.*);

`default_nettype wire

// ===== bench/midi_byte_stream_parser_unit_test.sv =====
// ----------------------------------------------------------------------------
// MIDI byte stream parser unit testbench
// Drives MIDI bytes into the slave port, predicts each decoded event with a
// behavioural parser and checks every master-side transfer field by field.
// A directed table covers every message kind, aborted and stray cases, then
// random well-formed messages mixed with broken ones follow, under random
// stalls on both sides, one long receiver hold-off and one full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module midi_byte_stream_parser_unit_test;

	import mbsp_pkg::*;

	localparam int unsigned USEFUL_TARGET  = 800;
	localparam int unsigned QUIET_FROM     = 700;
	localparam int unsigned LONG_HOLD      = 80;
	localparam int unsigned HOLD_AT        = 250;
	localparam int unsigned DRAIN_AT       = 500;
	localparam int unsigned SETTLE_CYCLES  = 8;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		kind_t kind;
		chan_t chan;
		data_t first_data;
		data_t second_data;
	} midi_event_t;

	typedef struct packed {
		logic [BYTE_W-1:0] midi_byte;
		bit                known;
		bit                known_hit;
		midi_event_t       known_ev;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [BYTE_W-1:0]     s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [TDATA_W-1:0]    m_tdata;
	logic [KIND_W-1:0]     m_tuser;

	midi_event_t           pending_events [$];
	logic [BYTE_W-1:0]     tx_bytes [$];
	stim_row_t             directed_rows [$];

	kind_t                 cur_kind;
	chan_t                 cur_chan;
	data_t                 cur_first;
	data_t                 cur_second;
	int unsigned           msg_len;
	int unsigned           still_needed;

	int unsigned           useful_sent;
	int unsigned           mismatch_count;
	int unsigned           idle_cycles;
	bit                    long_hold_req;

	midi_byte_stream_parser_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic stim_row_t row_free(input logic [BYTE_W-1:0] b);
		stim_row_t r;
		r = '0;
		r.midi_byte = b;
		return r;
	endfunction

	function automatic stim_row_t row_silent(input logic [BYTE_W-1:0] b);
		stim_row_t r;
		r = row_free(b);
		r.known = 1'b1;
		return r;
	endfunction

	function automatic stim_row_t row_event(input logic [BYTE_W-1:0] b, input kind_t k,
			input chan_t c, input data_t f, input data_t s);
		stim_row_t r;
		r = row_silent(b);
		r.known_hit = 1'b1;
		r.known_ev.kind = k;
		r.known_ev.chan = c;
		r.known_ev.first_data = f;
		r.known_ev.second_data = s;
		return r;
	endfunction

	function automatic bit idling_allowed();
		return useful_sent < QUIET_FROM && ((useful_sent / 80) % 4) != 3;
	endfunction

	// behavioural parser: returns 1 when the byte completes an event
	function automatic bit parse_midi_byte(input logic [BYTE_W-1:0] b,
			output midi_event_t ev, output bit useful);
		kind_t       k;
		chan_t       c;
		int unsigned n;
		ev = '0;
		useful = 1'b1;
		if (b[7]) begin
			k = KIND_NONE;
			c = CHAN_BROADCAST;
			n = 0;
			if (b[7:4] == 4'hF) begin
				case (b[3:0])
					4'h1: begin k = KIND_QUARTER_FRAME; n = 1; end
					4'h2: begin k = KIND_SONG_POS; n = 2; end
					4'h3: begin k = KIND_SONG_SELECT; n = 1; end
					4'h6: k = KIND_TUNE_REQ;
					4'h8: k = KIND_CLOCK;
					4'h9: k = KIND_TICK;
					4'hA: k = KIND_START;
					4'hB: k = KIND_CONTINUE;
					4'hC: k = KIND_STOP;
					4'hE: k = KIND_ACT_SENSE;
					4'hF: k = KIND_RESET;
					default: k = KIND_NONE;
				endcase
			end else begin
				c = {1'b0, b[3:0]};
				case (b[6:4])
					3'd0: begin k = KIND_NOTE_OFF; n = 2; end
					3'd1: begin k = KIND_NOTE_ON; n = 2; end
					3'd2: begin k = KIND_POLY_PRESSURE; n = 2; end
					3'd3: begin k = KIND_CTRL_CHANGE; n = 2; end
					3'd4: begin k = KIND_PROG_CHANGE; n = 1; end
					3'd5: begin k = KIND_CHAN_PRESSURE; n = 1; end
					default: begin k = KIND_PITCH_BEND; n = 2; end
				endcase
			end
			still_needed = 0;
			if (k == KIND_NONE)
				return 1'b0;
			cur_kind = k;
			cur_chan = c;
			cur_first = '0;
			cur_second = '0;
			msg_len = n;
			still_needed = n;
		end else begin
			if (still_needed == 0) begin
				useful = 1'b0;
				return 1'b0;
			end
			if (msg_len == 2 && still_needed == 2)
				cur_first = b[6:0];
			else if (msg_len == 2)
				cur_second = b[6:0];
			else
				cur_first = b[6:0];
			still_needed--;
		end
		if (still_needed != 0)
			return 1'b0;
		ev.kind = cur_kind;
		ev.chan = cur_chan;
		ev.first_data = cur_first;
		ev.second_data = cur_second;
		return 1'b1;
	endfunction

	task automatic send_row(input stim_row_t r);
		midi_event_t ev;
		bit          hit;
		bit          useful;
		if (idling_allowed() && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= r.midi_byte;
		do @(posedge clk); while (!s_tready);
		hit = parse_midi_byte(r.midi_byte, ev, useful);
		if (r.known) begin
			hit = r.known_hit;
			ev = r.known_ev;
		end
		if (hit)
			pending_events.push_back(ev);
		useful_sent += useful;
	endtask

	task automatic report_mismatch(input midi_event_t want, input midi_event_t got,
			input bit orphan);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			if (orphan)
				$display("unexpected event: kind %0d chan %0d data %0d %0d",
					got.kind, got.chan, got.first_data, got.second_data);
			else
				$display("event differs: expected kind %0d chan %0d data %0d %0d, got kind %0d chan %0d data %0d %0d",
					want.kind, want.chan, want.first_data, want.second_data,
					got.kind, got.chan, got.first_data, got.second_data);
		end
	endtask

	always @(posedge clk) begin
		midi_event_t want;
		midi_event_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.chan = m_tdata[4:0];
			got.first_data = m_tdata[11:5];
			got.second_data = m_tdata[18:12];
			if (pending_events.size() == 0) begin
				report_mismatch('0, got, 1'b1);
			end else begin
				want = pending_events.pop_front();
				if (got.kind !== want.kind || got.chan !== want.chan ||
						got.first_data !== want.first_data ||
						got.second_data !== want.second_data)
					report_mismatch(want, got, 1'b0);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("midi_byte_stream_parser_unit: mismatch");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		int unsigned hold_left;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_tready <= 1'b0;
				for (hold_left = LONG_HOLD; hold_left > 0; hold_left--)
					@(posedge clk);
				m_tready <= 1'b1;
			end else if (idling_allowed() && $urandom_range(0, 6) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned pick;
		int unsigned n_data;
		int unsigned i;
		logic [3:0]  nib;
		logic [7:0]  status;
		bit          with_status;
		bit          sysex;
		bit          hold_done;
		bit          drain_done;

		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		useful_sent = 0;
		mismatch_count = 0;
		idle_cycles = 0;
		long_hold_req = 1'b0;
		hold_done = 1'b0;
		drain_done = 1'b0;
		cur_kind = '0;
		cur_chan = CHAN_BROADCAST;
		cur_first = '0;
		cur_second = '0;
		msg_len = 0;
		still_needed = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_rows = '{
			row_event(8'hFA, KIND_START, CHAN_BROADCAST, 7'd0, 7'd0),
			row_silent(8'h00),
			row_free(8'h90), row_free(8'h00),
			row_event(8'h7F, KIND_NOTE_ON, 5'd0, 7'd0, 7'd127),
			row_free(8'h8F), row_free(8'h7F),
			row_event(8'h00, KIND_NOTE_OFF, 5'd15, 7'd127, 7'd0),
			row_free(8'hA5), row_free(8'h12), row_free(8'hF8), row_free(8'h34),
			row_free(8'hA5), row_free(8'h01), row_free(8'h02),
			row_free(8'hB3), row_free(8'h07), row_free(8'h64),
			row_free(8'hC9), row_free(8'h05),
			row_free(8'hDE), row_free(8'h40),
			row_free(8'hE0), row_free(8'h00), row_free(8'h40),
			row_free(8'hF1), row_free(8'h33),
			row_free(8'hF2), row_free(8'h10), row_free(8'h20),
			row_free(8'hF3), row_free(8'h05),
			row_free(8'hF6), row_free(8'hF9), row_free(8'hFB), row_free(8'hFC),
			row_free(8'hFE),
			row_event(8'hFF, KIND_RESET, CHAN_BROADCAST, 7'd0, 7'd0),
			row_silent(8'hF0), row_free(8'h01), row_silent(8'hF7),
			row_silent(8'hF4), row_silent(8'hF5), row_silent(8'hFD)
		};
		foreach (directed_rows[k])
			send_row(directed_rows[k]);

		while (useful_sent < USEFUL_TARGET) begin
			if (tx_bytes.size() == 0) begin
				pick = $urandom_range(0, 99);
				with_status = 1'b1;
				sysex = 1'b0;
				n_data = 0;
				status = 8'hF8;
				if (pick < 60) begin
					nib = 4'($urandom_range(8, 14));
					status = {nib, 4'($urandom_range(0, 15))};
					n_data = (nib == 4'hC || nib == 4'hD) ? 1 : 2;
				end else if (pick < 74) begin
					case ($urandom_range(0, 3))
						0: begin status = 8'hF1; n_data = 1; end
						1: begin status = 8'hF2; n_data = 2; end
						2: begin status = 8'hF3; n_data = 1; end
						default: status = 8'hF6;
					endcase
				end else if (pick < 86) begin
					status = 8'($urandom_range(8'hF8, 8'hFF));
				end else if (pick < 92) begin
					status = 8'hF0;
					sysex = 1'b1;
					n_data = $urandom_range(1, 6);
				end else if (pick < 96) begin
					case ($urandom_range(0, 2))
						0: status = 8'hF4;
						1: status = 8'hF5;
						default: status = 8'hFD;
					endcase
				end else begin
					with_status = 1'b0;
					n_data = $urandom_range(1, 3);
				end
				if (with_status)
					tx_bytes.push_back(status);
				for (i = 0; i < n_data; i++) begin
					// cut short or interleave a realtime byte now and then
					if (with_status && !sysex && $urandom_range(0, 19) == 0)
						break;
					if (with_status && $urandom_range(0, 19) == 0)
						tx_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
					tx_bytes.push_back({1'b0, 7'($urandom_range(0, 127))});
				end
				if (sysex && $urandom_range(0, 3) != 0)
					tx_bytes.push_back(8'hF7);
			end
			send_row(row_free(tx_bytes.pop_front()));
			if (!hold_done && useful_sent >= HOLD_AT) begin
				hold_done = 1'b1;
				long_hold_req = 1'b1;
			end
			if (!drain_done && useful_sent >= DRAIN_AT) begin
				drain_done = 1'b1;
				s_tvalid <= 1'b0;
				do @(posedge clk); while (pending_events.size() != 0);
			end
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_events.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("midi_byte_stream_parser_unit: match");
		else
			$display("midi_byte_stream_parser_unit: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/mbsp_pkg.sv
hw/rtl/midi_byte_stream_parser_unit.sv
hw/rtl/mbsp_checker.sv
bench/midi_byte_stream_parser_unit_test.sv
